FILE: rtl/uve_pkg.sv
`timescale 1ns / 1ps

package uve_pkg;

    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_ESCAPE_HASH = 3'd0;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       name_invalid;
    } t_out_item;

    // bytes to be written out for one request, in order
    typedef struct packed {
        logic [2:0]      count;
        logic [3:0][7:0] bytes;
        logic [3:0]      esc;
        logic            last;
        logic            invalid;
    } t_entries;

    typedef enum logic [1:0] {
        V_OK,
        V_FLAG,
        V_HASH
    } t_verdict;

    typedef enum logic [1:0] {
        OP_ACCEPT,
        OP_LOAD,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        EM_RAW,
        EM_HASH,
        EM_LPAREN,
        EM_HUND,
        EM_TENS,
        EM_ONES,
        EM_RPAREN
    } t_emit;

    typedef enum logic [1:0] {
        C_ALWAYS,
        C_HUND,
        C_TENS
    } t_cond;

    typedef struct packed {
        t_op        op;
        t_emit      emit;
        t_cond      cond;
        logic       fin;
        logic [3:0] next;
    } t_uword;

    localparam logic [3:0] PC_ACCEPT = 4'd0;
    localparam logic [3:0] PC_LOAD   = 4'd1;
    localparam logic [3:0] PC_HASH   = 4'd2;
    localparam logic [3:0] PC_LPAREN = 4'd3;
    localparam logic [3:0] PC_HUND   = 4'd4;
    localparam logic [3:0] PC_TENS   = 4'd5;
    localparam logic [3:0] PC_ONES   = 4'd6;
    localparam logic [3:0] PC_RPAREN = 4'd7;
    localparam logic [3:0] PC_RAW    = 4'd8;

    // control store
    function automatic t_uword ucode(input logic [3:0] pc);
        t_uword w;
        unique case (pc)
            PC_ACCEPT: w = '{OP_ACCEPT, EM_RAW,    C_ALWAYS, 1'b0, PC_LOAD};
            PC_LOAD:   w = '{OP_LOAD,   EM_RAW,    C_ALWAYS, 1'b0, PC_HASH};
            PC_HASH:   w = '{OP_EMIT,   EM_HASH,   C_ALWAYS, 1'b0, PC_LPAREN};
            PC_LPAREN: w = '{OP_EMIT,   EM_LPAREN, C_ALWAYS, 1'b0, PC_HUND};
            PC_HUND:   w = '{OP_EMIT,   EM_HUND,   C_HUND,   1'b0, PC_TENS};
            PC_TENS:   w = '{OP_EMIT,   EM_TENS,   C_TENS,   1'b0, PC_ONES};
            PC_ONES:   w = '{OP_EMIT,   EM_ONES,   C_ALWAYS, 1'b0, PC_RPAREN};
            PC_RPAREN: w = '{OP_EMIT,   EM_RPAREN, C_ALWAYS, 1'b1, PC_LOAD};
            PC_RAW:    w = '{OP_EMIT,   EM_RAW,    C_ALWAYS, 1'b1, PC_LOAD};
            default:   w = '{OP_ACCEPT, EM_RAW,    C_ALWAYS, 1'b0, PC_LOAD};
        endcase
        return w;
    endfunction

    function automatic logic [3:0] lead_ones(input logic [7:0] b);
        logic [3:0] n;
        logic       stop;
        n    = '0;
        stop = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!stop && b[i]) begin
                n = n + 4'd1;
            end else begin
                stop = 1'b1;
            end
        end
        return n;
    endfunction

    // double dabble, hundreds in [11:8], tens in [7:4], ones in [3:0]
    function automatic logic [11:0] to_bcd(input logic [7:0] b);
        logic [11:0] d;
        d = '0;
        for (int i = 7; i >= 0; i--) begin
            if (d[3:0] >= 4'd5) d[3:0] = d[3:0] + 4'd3;
            if (d[7:4] >= 4'd5) d[7:4] = d[7:4] + 4'd3;
            d = {d[10:0], b[i]};
        end
        return d;
    endfunction

    function automatic t_verdict judge(input logic [15:0] cp, input logic esc_hash);
        t_verdict v;
        if (cp < 16'd32 || (cp >= 16'h0080 && cp <= 16'h009F)) begin
            v = V_FLAG;
        end else if (esc_hash && cp == {8'h00, CH_HASH}) begin
            v = V_HASH;
        end else begin
            v = V_OK;
        end
        return v;
    endfunction

endpackage

FILE: rtl/uve_front.sv
`timescale 1ns / 1ps

module uve_front
    import uve_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    input  logic     i_escape_hash,
    output t_entries o_ent
);

    logic [2:0][7:0] r_pend, n_pend;
    logic [1:0]      r_pcnt, n_pcnt;
    logic [1:0]      r_togo, n_togo;
    logic [15:0]     r_acc,  n_acc;
    logic            r_flag, n_flag;

    always_comb begin
        t_entries   ent;
        logic [7:0] b;
        logic [3:0] hb;
        logic       fresh;
        logic       do_fin;
        logic       esc_all;
        t_verdict   verdict;

        n_pend  = r_pend;
        n_pcnt  = r_pcnt;
        n_togo  = r_togo;
        n_acc   = r_acc;
        n_flag  = r_flag;
        ent     = '0;
        b       = i_item.in_byte;
        hb      = lead_ones(b);
        fresh   = 1'b1;
        do_fin  = 1'b0;
        esc_all = 1'b0;
        verdict = V_OK;

        if (r_togo != 2'd0) begin
            if (hb != 4'd1) begin
                // mismatch: pending bytes go out escaped, byte starts afresh
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) < n_pcnt) begin
                        ent.bytes[ent.count[1:0]] = n_pend[i];
                        ent.esc[ent.count[1:0]]   = 1'b1;
                        ent.count                 = ent.count + 3'd1;
                    end
                end
                n_pcnt = '0;
                n_flag = 1'b1;
                n_togo = '0;
            end else begin
                fresh  = 1'b0;
                n_acc  = {r_acc[9:0], b[5:0]};
                n_togo = r_togo - 2'd1;
                if (n_togo == 2'd0) begin
                    do_fin = 1'b1;
                end else if (n_pcnt != 2'd3) begin
                    n_pend[n_pcnt] = b;
                    n_pcnt         = n_pcnt + 2'd1;
                end
            end
        end

        if (fresh) begin
            if (hb == 4'd1 || hb > 4'd4) begin
                ent.bytes[ent.count[1:0]] = b;
                ent.esc[ent.count[1:0]]   = 1'b1;
                ent.count                 = ent.count + 3'd1;
                n_flag                    = 1'b1;
            end else if (hb == 4'd0) begin
                n_acc  = {8'h00, b};
                do_fin = 1'b1;
            end else begin
                n_acc     = {8'h00, b & (8'hFF >> hb)};
                n_pend[0] = b;
                n_pcnt    = 2'd1;
                n_togo    = 2'(hb - 4'd1);
            end
        end

        if (do_fin) begin
            verdict = judge(n_acc, i_escape_hash);
            esc_all = (verdict != V_OK);
            if (verdict == V_FLAG) n_flag = 1'b1;
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < n_pcnt) begin
                    ent.bytes[ent.count[1:0]] = n_pend[i];
                    ent.esc[ent.count[1:0]]   = esc_all;
                    ent.count                 = ent.count + 3'd1;
                end
            end
            n_pcnt                    = '0;
            ent.bytes[ent.count[1:0]] = b;
            ent.esc[ent.count[1:0]]   = esc_all;
            ent.count                 = ent.count + 3'd1;
        end

        ent.last = i_item.in_last;
        if (i_item.in_last) begin
            // truncated sequence at end of name
            if (n_togo != 2'd0) begin
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) < n_pcnt) begin
                        ent.bytes[ent.count[1:0]] = n_pend[i];
                        ent.esc[ent.count[1:0]]   = 1'b1;
                        ent.count                 = ent.count + 3'd1;
                    end
                end
                n_flag = 1'b1;
                n_togo = '0;
            end
            ent.invalid = n_flag;
            n_flag      = 1'b0;
            n_acc       = '0;
            n_pcnt      = '0;
        end

        o_ent = ent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt <= '0;
            r_togo <= '0;
            r_acc  <= '0;
            r_flag <= 1'b0;
        end else if (i_accept) begin
            r_pcnt <= n_pcnt;
            r_togo <= n_togo;
            r_acc  <= n_acc;
            r_flag <= n_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pend <= n_pend;
        end
    end

endmodule

FILE: rtl/utf8_validate_escape_top.sv
`timescale 1ns / 1ps

// utf8 name validator and escaper
// input channel: one name byte per request (i_in_valid / o_in_stall), in_last
// on the final byte of a name. output channel: escaped text bytes
// (o_out_valid / i_out_stall); out_last marks the final byte of the name and
// name_invalid on that byte tells whether a violation other than '#' was seen.
// register escape_hash at address 0 over the apb port, 1 after reset.
// a request is taken in the accept step, then a microcoded sequencer walks
// the bytes it released (at most four): a load step for each byte, then a
// copy step for a plain byte or the fixed "#(ddd)" program for an escaped
// one (hash, open paren, hundreds, tens, ones, close paren; skipped digits
// still take their step), and a closing load step. a request that releases
// no bytes (a lead or continuation byte that is only held) ends in its
// accept step. o_in_stall is high whenever the program is running.
// when the receiver stalls, the output register holds its byte and the
// sequencer waits on the step that wants to write it.
// reset clears the sequence state, the output valid flag and the program
// counter; the block is ready to take a request as soon as reset is released.

module utf8_validate_escape_top
    import uve_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_uword     uw;
    t_entries   ent;
    logic       accept;
    logic       out_free;
    logic       emit_en;
    logic [7:0] emit_byte;
    logic [11:0] bcd;

    logic [3:0]      r_pc;
    logic            r_ov;
    t_out_item       r_ob;
    logic [2:0]      r_idx;
    logic [2:0]      r_cnt;
    logic            r_escape_hash;
    logic [3:0][7:0] r_ent_byte;
    logic [3:0]      r_ent_esc;
    logic            r_item_last;
    logic            r_item_inv;
    logic [7:0]      r_cur_byte;
    logic [3:0]      r_hund;
    logic [3:0]      r_tens;
    logic [3:0]      r_ones;
    logic            r_cur_final;

    assign uw         = ucode(r_pc);
    assign o_in_stall = (uw.op != OP_ACCEPT);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_ov || !i_out_stall;
    assign bcd        = to_bcd(r_ent_byte[r_idx[1:0]]);

    assign o_out_valid = r_ov;
    assign o_out_data  = r_ob;
    assign pready      = 1'b1;
    assign prdata      = (paddr == ADDR_ESCAPE_HASH) ? {31'b0, r_escape_hash} : '0;

    uve_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (i_in_data),
        .i_escape_hash (r_escape_hash),
        .o_ent         (ent)
    );

    always_comb begin
        case (uw.cond)
            C_HUND:  emit_en = (r_hund != 4'd0);
            C_TENS:  emit_en = (r_hund != 4'd0) || (r_tens != 4'd0);
            default: emit_en = 1'b1;
        endcase
    end

    always_comb begin
        unique case (uw.emit)
            EM_RAW:    emit_byte = r_cur_byte;
            EM_HASH:   emit_byte = CH_HASH;
            EM_LPAREN: emit_byte = CH_LPAREN;
            EM_HUND:   emit_byte = CH_ZERO + {4'b0, r_hund};
            EM_TENS:   emit_byte = CH_ZERO + {4'b0, r_tens};
            EM_ONES:   emit_byte = CH_ZERO + {4'b0, r_ones};
            EM_RPAREN: emit_byte = CH_RPAREN;
            default:   emit_byte = r_cur_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc          <= PC_ACCEPT;
            r_ov          <= 1'b0;
            r_idx         <= '0;
            r_cnt         <= '0;
            r_escape_hash <= 1'b1;
        end else begin
            if (psel && penable && pwrite && paddr == ADDR_ESCAPE_HASH) begin
                r_escape_hash <= pwdata[0];
            end
            // a new byte enters the output register, or a stalled one stays
            r_ov <= (uw.op == OP_EMIT && emit_en && out_free) || (r_ov && i_out_stall);
            unique case (uw.op)
                OP_ACCEPT: begin
                    if (accept) begin
                        r_cnt <= ent.count;
                        r_idx <= '0;
                        r_pc  <= (ent.count != 3'd0) ? uw.next : PC_ACCEPT;
                    end
                end
                OP_LOAD: begin
                    if (r_idx == r_cnt) begin
                        r_pc <= PC_ACCEPT;
                    end else begin
                        r_idx <= r_idx + 3'd1;
                        r_pc  <= r_ent_esc[r_idx[1:0]] ? uw.next : PC_RAW;
                    end
                end
                OP_EMIT: begin
                    if (!emit_en) begin
                        r_pc <= uw.next;
                    end else if (out_free) begin
                        r_pc <= uw.next;
                    end
                end
                default: r_pc <= PC_ACCEPT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ent_byte  <= ent.bytes;
            r_ent_esc   <= ent.esc;
            r_item_last <= ent.last;
            r_item_inv  <= ent.invalid;
        end
        if (uw.op == OP_LOAD && r_idx != r_cnt) begin
            r_cur_byte  <= r_ent_byte[r_idx[1:0]];
            r_hund      <= bcd[11:8];
            r_tens      <= bcd[7:4];
            r_ones      <= bcd[3:0];
            r_cur_final <= r_item_last && (r_idx + 3'd1 == r_cnt);
        end
        if (uw.op == OP_EMIT && emit_en && out_free) begin
            r_ob.out_byte     <= emit_byte;
            r_ob.out_last     <= uw.fin && r_cur_final;
            r_ob.name_invalid <= uw.fin && r_cur_final && r_item_inv;
        end
    end

endmodule

FILE: rtl/uve_checker.sv
`timescale 1ns / 1ps

module uve_checker
    import uve_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // stalled output byte is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");

    // the verdict only travels with the final byte of a name
    a_inv_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.name_invalid && !o_out_data.out_last))
        else $error("name_invalid without out_last");

    // leaving reset, the block is empty and ready for a request
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_in_stall && !o_out_valid)
        else $error("block not idle after reset");

endmodule

bind utf8_validate_escape_top uve_checker u_uve_checker (.*);

FILE: tb/tb_utf8_validate_escape_top.sv
`timescale 1ns / 1ps

module tb_utf8_validate_escape_top;
    import uve_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    t_in_item           i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_item          o_out_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    utf8_validate_escape_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // escaper state as seen by the checker
    logic        esc_hash_en = 1'b1;
    logic [7:0]  held_bytes [3];
    logic [1:0]  held_count = '0;
    logic [1:0]  conts_left = '0;
    logic [15:0] code_pt = '0;
    logic        name_bad = 1'b0;
    int          step_results = 0;

    logic [7:0]  name_buf [$];
    t_in_item    name_bytes [$];
    t_out_item   text_expected [$];
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic        in_taken = 1'b0;

    task automatic push_text(input logic [7:0] b);
        t_out_item r;
        r.out_byte     = b;
        r.out_last     = 1'b0;
        r.name_invalid = 1'b0;
        text_expected.push_back(r);
        step_results++;
    endtask

    task automatic push_escaped(input logic [7:0] b);
        push_text(CH_HASH);
        push_text(CH_LPAREN);
        if (b >= 8'd100) push_text(CH_ZERO + b / 8'd100);
        if (b >= 8'd10) push_text(CH_ZERO + (b / 8'd10) % 8'd10);
        push_text(CH_ZERO + b % 8'd10);
        push_text(CH_RPAREN);
    endtask

    task automatic flush_held(input logic escaped);
        for (int i = 0; i < held_count; i++) begin
            if (escaped) begin
                push_escaped(held_bytes[i]);
            end else begin
                push_text(held_bytes[i]);
            end
        end
        held_count = '0;
    endtask

    // end of a sequence: judge the code point, copy or escape all its bytes
    task automatic close_seq(input logic [7:0] b);
        t_verdict v;
        if (code_pt < 16'd32 || (code_pt >= 16'h0080 && code_pt <= 16'h009F)) begin
            v = V_FLAG;
        end else if (esc_hash_en && code_pt == {8'h00, CH_HASH}) begin
            v = V_HASH;
        end else begin
            v = V_OK;
        end
        if (v == V_FLAG) name_bad = 1'b1;
        flush_held(v != V_OK);
        if (v != V_OK) begin
            push_escaped(b);
        end else begin
            push_text(b);
        end
    endtask

    task automatic step_escaper(input t_in_item it);
        logic [7:0] b;
        int         ones;
        logic       fresh;
        b     = it.in_byte;
        ones  = 0;
        while (ones < 8 && b[7 - ones]) ones++;
        fresh = 1'b1;
        step_results = 0;
        if (conts_left != 0) begin
            if (ones != 1) begin
                // mismatch: held bytes go out escaped, byte starts afresh
                flush_held(1'b1);
                name_bad   = 1'b1;
                conts_left = '0;
            end else begin
                fresh   = 1'b0;
                code_pt = (code_pt << 6) + {10'd0, b[5:0]};
                conts_left--;
                if (conts_left == 0) begin
                    close_seq(b);
                end else if (held_count < 3) begin
                    held_bytes[held_count] = b;
                    held_count++;
                end
            end
        end
        if (fresh) begin
            if (ones == 1 || ones > 4) begin
                push_escaped(b);
                name_bad = 1'b1;
            end else if (ones == 0) begin
                code_pt = {8'd0, b};
                close_seq(b);
            end else begin
                code_pt       = {8'd0, b & (8'hFF >> ones)};
                held_bytes[0] = b;
                held_count    = 2'd1;
                conts_left    = 2'(ones - 1);
            end
        end
        if (it.in_last) begin
            if (conts_left != 0) begin
                // name ends inside a sequence
                flush_held(1'b1);
                name_bad   = 1'b1;
                conts_left = '0;
            end
            if (step_results > 0) begin
                text_expected[text_expected.size() - 1].out_last     = 1'b1;
                text_expected[text_expected.size() - 1].name_invalid = name_bad;
            end
            name_bad   = 1'b0;
            code_pt    = '0;
            held_count = '0;
        end
    endtask

    // monitor: check outputs first, then predict from the accepted request
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            in_taken <= i_in_valid && !o_in_stall;
            if (o_out_valid && !i_out_stall) begin
                if (text_expected.size() == 0) begin
                    $error("out_byte: expected nothing, got %0d", o_out_data.out_byte);
                    fail_count++;
                end else begin
                    want = text_expected.pop_front();
                    if (o_out_data.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0d, got %0d",
                               want.out_byte, o_out_data.out_byte);
                        fail_count++;
                    end
                    if (o_out_data.out_last !== want.out_last) begin
                        $error("out_last: expected %0b, got %0b",
                               want.out_last, o_out_data.out_last);
                        fail_count++;
                    end
                    if (o_out_data.name_invalid !== want.name_invalid) begin
                        $error("name_invalid: expected %0b, got %0b",
                               want.name_invalid, o_out_data.name_invalid);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) step_escaper(i_in_data);
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            if (!i_in_valid || in_taken) begin
                if (name_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= name_bytes.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic queue_name();
        t_in_item it;
        for (int i = 0; i < name_buf.size(); i++) begin
            it.in_byte = name_buf[i];
            it.in_last = (i == name_buf.size() - 1);
            name_bytes.push_back(it);
        end
        name_buf.delete();
    endtask

    task automatic add_random_char();
        int pick;
        int k;
        pick = $urandom_range(99);
        if (pick < 33) begin
            name_buf.push_back(8'($urandom_range(8'h7F, 8'h20)));
        end else if (pick < 38) begin
            name_buf.push_back(CH_HASH);
        end else if (pick < 43) begin
            name_buf.push_back(8'($urandom_range(8'h1F, 8'h01)));
        end else if (pick < 60) begin
            name_buf.push_back(8'($urandom_range(8'hDF, 8'hC0)));
            name_buf.push_back(8'($urandom_range(8'hBF, 8'h80)));
        end else if (pick < 72) begin
            name_buf.push_back(8'($urandom_range(8'hEF, 8'hE0)));
            repeat (2) name_buf.push_back(8'($urandom_range(8'hBF, 8'h80)));
        end else if (pick < 80) begin
            name_buf.push_back(8'($urandom_range(8'hF7, 8'hF0)));
            repeat (3) name_buf.push_back(8'($urandom_range(8'hBF, 8'h80)));
        end else if (pick < 85) begin
            // c1 control in two bytes
            name_buf.push_back(8'hC2);
            name_buf.push_back(8'($urandom_range(8'h9F, 8'h80)));
        end else if (pick < 90) begin
            // stray continuation or over-long lead
            if ($urandom_range(1)) begin
                name_buf.push_back(8'($urandom_range(8'hBF, 8'h80)));
            end else begin
                name_buf.push_back(8'($urandom_range(8'hFF, 8'hF8)));
            end
        end else begin
            // lead with too few continuations
            k = $urandom_range(3, 1);
            case (k)
                1:       name_buf.push_back(8'($urandom_range(8'hDF, 8'hC0)));
                2:       name_buf.push_back(8'($urandom_range(8'hEF, 8'hE0)));
                default: name_buf.push_back(8'($urandom_range(8'hF7, 8'hF0)));
            endcase
            repeat ($urandom_range(k - 1, 0))
                name_buf.push_back(8'($urandom_range(8'hBF, 8'h80)));
        end
    endtask

    task automatic write_escape_hash(input logic v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ESCAPE_HASH;
        pwdata  <= {31'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        esc_hash_en = v;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // sender holds off until every expected byte is out, then a quiet margin
    task automatic wait_drained();
        while (name_bytes.size() != 0 || i_in_valid || text_expected.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        int phase_bytes;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed names, escape_hash still at its reset value
        name_buf = '{8'h41, 8'h23, 8'h01, 8'h7F, 8'hFF, 8'h80};
        queue_name();
        name_buf = '{8'hC2, 8'h85, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
        queue_name();
        name_buf = '{8'hE2, 8'h41, 8'hF8, 8'hC3};
        queue_name();
        name_buf = '{8'h20};
        queue_name();
        name_buf = '{8'hC0, 8'h80};
        queue_name();
        name_buf = '{8'hF4, 8'h8F};
        queue_name();
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            write_escape_hash(p % 2 == 1);
            case (p)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 66; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 66; end
                default: begin send_idle_pct = 20; stall_pct = 20; end
            endcase
            phase_bytes = 0;
            while (phase_bytes < 52) begin
                repeat ($urandom_range(6, 1)) add_random_char();
                phase_bytes += name_buf.size();
                queue_name();
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("utf8_validate_escape_top verification clean");
        end else begin
            $display("utf8_validate_escape_top verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("utf8_validate_escape_top verification failed");
        $finish;
    end

endmodule
